[rtl/bitmap_frame_allocator_defines.svh]
// Assertion macros used by the frame allocator engine RTL.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define BFA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame allocator check failed");

// Next-cycle implication, disabled while reset is high
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame allocator check failed");

`endif

[rtl/bfa_pkg.sv]
// Shared constants, types and helpers of the bitmap frame allocator.
package bfa_pkg;

   // Geometry
   localparam int MAX_BLOCKS  = 32768;
   localparam int BLOCK_BYTES = 4096;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int WORD_BITS   = 32;
   localparam int BIT_AW      = $clog2(WORD_BITS);
   localparam int WORD_COUNT  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW     = $clog2(WORD_COUNT);
   localparam int BLK_AW      = WORD_AW + BIT_AW;
   localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);

   // Field widths
   localparam int FUNC_W     = 3;
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 32;
   localparam int SUM_W      = ADDR_W + 1;
   localparam int MKB_W      = 18;
   localparam int OUT_CNT_W  = 16;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 1;

   localparam logic [MKB_W-1:0] MKB_RESET = 18'd131072;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_INIT           = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE_REGION    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESERVE_REGION = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC          = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FREE_ONE       = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] size_bytes;
   } bfa_cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    block_address;
      logic                 success;
      logic [OUT_CNT_W-1:0] used_blocks;
      logic [OUT_CNT_W-1:0] free_blocks;
   } bfa_rsp_type;

   // Usable block count: kilobytes * 1024 / block size, capped at MAX_BLOCKS
   function automatic logic [CNT_W-1:0] bfa_block_total(input logic [MKB_W-1:0] mkb);
      logic [MKB_W+9:0] bytes_v;
      logic [MKB_W+9:0] blocks_v;
      bytes_v  = {mkb, 10'b0};
      blocks_v = bytes_v >> BLOCK_SHIFT;
      if (blocks_v > (MKB_W+10)'(MAX_BLOCKS)) begin
         return CNT_W'(MAX_BLOCKS);
      end
      return CNT_W'(blocks_v);
   endfunction

endpackage

[rtl/bfa_engine.sv]
// Bitmap store and operation sequencer of the frame allocator.
`include "bitmap_frame_allocator_defines.svh"

module bfa_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  bfa_pkg::bfa_cmd_type      cmd,
   input  logic [bfa_pkg::CNT_W-1:0] total,
   input  logic                      out_free,
   output logic                      idle,
   output logic                      rsp_valid,
   output bfa_pkg::bfa_rsp_type      rsp
);
   import bfa_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RPREP, ST_RWALK, ST_RCNT, ST_FIX_RD, ST_FIX_WR,
      ST_SCAN, ST_F1_RD, ST_F1_WR, ST_REPORT
   } state_type;

   localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

   // Control registers
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [WORD_AW-1:0] sweep_ff, sweep_in;
   logic               rep_after_ff, rep_after_in;
   logic               wr_pend_ff, wr_pend_in;
   logic               issue_done_ff, issue_done_in;
   logic               chk_ff, chk_in;

   // Payload registers
   logic [SUM_W-1:0]   s_ff, s_in;
   logic [SUM_W-1:0]   e_ff, e_in;
   logic               set_ff, set_in;
   logic [BLK_AW-1:0]  start_blk_ff, start_blk_in;
   logic [BLK_AW-1:0]  last_blk_ff, last_blk_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [WORD_AW-1:0] rd_word_ff, rd_word_in;
   logic [WORD_AW-1:0] wr_word_ff, wr_word_in;
   logic [WORD_AW:0]   words_ff, words_in;
   logic [WORD_AW:0]   nxt_ff, nxt_in;
   logic [WORD_AW-1:0] chk_word_ff, chk_word_in;
   logic [BLK_AW-1:0]  blk_ff, blk_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               ok_ff, ok_in;

   // Memory port
   logic [WORD_BITS-1:0] bitmap_mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 mem_we;
   logic [WORD_AW-1:0]   mem_waddr;
   logic [WORD_AW-1:0]   mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata;

   // Helpers
   logic [SUM_W-1:0]     cmd_page;
   logic [CNT_W-1:0]     ec;
   logic [CNT_W-1:0]     ec_m1;
   logic                 nonempty;
   logic [BIT_AW-1:0]    lo_bit;
   logic [BIT_AW-1:0]    hi_bit;
   logic [WORD_BITS-1:0] walk_mask;
   logic                 found;
   logic [BIT_AW-1:0]    zero_bit;
   logic [BLK_AW-1:0]    found_blk;
   logic [CNT_W:0]       res_sum;
   logic [CNT_W-1:0]     free_cnt;

   // Lowest clear bit of a word
   function automatic logic [BIT_AW-1:0] first_zero(input logic [WORD_BITS-1:0] v);
      logic [BIT_AW-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!v[i]) begin
            idx = BIT_AW'(i);
         end
      end
      return idx;
   endfunction

   assign cmd_page = SUM_W'(cmd.address >> BLOCK_SHIFT);

   // Region end clamped to the block count
   assign ec       = (e_ff > SUM_W'(total)) ? total : e_ff[CNT_W-1:0];
   assign ec_m1    = ec - 1'b1;
   assign nonempty = SUM_W'(ec) > s_ff;

   // Bits of the word being written that fall inside the region
   assign lo_bit    = (wr_word_ff == start_blk_ff[BLK_AW-1:BIT_AW]) ?
                      start_blk_ff[BIT_AW-1:0] : '0;
   assign hi_bit    = (wr_word_ff == last_blk_ff[BLK_AW-1:BIT_AW]) ?
                      last_blk_ff[BIT_AW-1:0] : '1;
   assign walk_mask = (ONES << lo_bit) & (ONES >> (BIT_AW'(WORD_BITS - 1) - hi_bit));

   // Allocation search result
   assign found     = chk_ff && (rdata_ff != ONES);
   assign zero_bit  = first_zero(rdata_ff);
   assign found_blk = {chk_word_ff, zero_bit};

   assign res_sum  = {1'b0, used_ff} + {1'b0, n_ff};
   assign free_cnt = (total > used_ff) ? (total - used_ff) : '0;

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      sweep_in      = sweep_ff;
      rep_after_in  = rep_after_ff;
      wr_pend_in    = wr_pend_ff;
      issue_done_in = issue_done_ff;
      chk_in        = chk_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      set_in        = set_ff;
      start_blk_in  = start_blk_ff;
      last_blk_in   = last_blk_ff;
      n_in          = n_ff;
      rd_word_in    = rd_word_ff;
      wr_word_in    = wr_word_ff;
      words_in      = words_ff;
      nxt_in        = nxt_ff;
      chk_word_in   = chk_word_ff;
      blk_in        = blk_ff;
      res_addr_in   = res_addr_ff;
      ok_in         = ok_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_raddr     = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = ONES;
            if (sweep_ff == WORD_AW'(WORD_COUNT - 1)) begin
               state_in = rep_after_ff ? ST_REPORT : ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               res_addr_in = '0;
               ok_in       = 1'b0;
               s_in        = cmd_page;
               e_in        = cmd_page + SUM_W'(cmd.size_bytes >> BLOCK_SHIFT);
               set_in      = (cmd.func == FUNC_RESERVE_REGION);
               case (cmd.func)
                  FUNC_INIT: begin
                     used_in      = total;
                     sweep_in     = '0;
                     rep_after_in = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  FUNC_FREE_REGION, FUNC_RESERVE_REGION: begin
                     state_in = ST_RPREP;
                  end
                  FUNC_ALLOC: begin
                     if (used_ff < total) begin
                        nxt_in   = '0;
                        chk_in   = 1'b0;
                        words_in = (WORD_AW + 1)'(total >> BIT_AW);
                        state_in = ST_SCAN;
                     end else begin
                        state_in = ST_REPORT;
                     end
                  end
                  FUNC_FREE_ONE: begin
                     if (cmd_page < SUM_W'(total)) begin
                        blk_in   = cmd_page[BLK_AW-1:0];
                        state_in = ST_F1_RD;
                     end else begin
                        state_in = ST_REPORT;
                     end
                  end
                  default: begin
                     state_in = ST_REPORT;
                  end
               endcase
            end
         end
         ST_RPREP: begin
            if (nonempty) begin
               start_blk_in  = s_ff[BLK_AW-1:0];
               last_blk_in   = ec_m1[BLK_AW-1:0];
               n_in          = ec - s_ff[CNT_W-1:0];
               rd_word_in    = s_ff[BLK_AW-1:BIT_AW];
               issue_done_in = 1'b0;
               wr_pend_in    = 1'b0;
               state_in      = ST_RWALK;
            end else begin
               n_in     = '0;
               state_in = ST_RCNT;
            end
         end
         ST_RWALK: begin
            // write back the word read last cycle
            if (wr_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_word_ff;
               mem_wdata = set_ff ? (rdata_ff | walk_mask) : (rdata_ff & ~walk_mask);
            end
            // read the next word of the region
            if (!issue_done_ff) begin
               mem_raddr  = rd_word_ff;
               wr_pend_in = 1'b1;
               wr_word_in = rd_word_ff;
               if (rd_word_ff == last_blk_ff[BLK_AW-1:BIT_AW]) begin
                  issue_done_in = 1'b1;
               end else begin
                  rd_word_in = rd_word_ff + 1'b1;
               end
            end else begin
               wr_pend_in = 1'b0;
               state_in   = ST_RCNT;
            end
         end
         ST_RCNT: begin
            if (set_ff) begin
               if (used_ff < total) begin
                  used_in = (res_sum > {1'b0, total}) ? total : res_sum[CNT_W-1:0];
               end
               state_in = ST_REPORT;
            end else begin
               used_in  = (used_ff > n_ff) ? (used_ff - n_ff) : '0;
               state_in = (total != '0) ? ST_FIX_RD : ST_REPORT;
            end
         end
         ST_FIX_RD: begin
            mem_raddr = '0;
            state_in  = ST_FIX_WR;
         end
         ST_FIX_WR: begin
            // block 0 stays reserved after a region free
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = rdata_ff | WORD_BITS'(1);
            state_in  = ST_REPORT;
         end
         ST_SCAN: begin
            mem_raddr = nxt_ff[WORD_AW-1:0];
            if (found) begin
               mem_we      = 1'b1;
               mem_waddr   = chk_word_ff;
               mem_wdata   = rdata_ff | (WORD_BITS'(1) << zero_bit);
               used_in     = used_ff + 1'b1;
               res_addr_in = ADDR_W'({found_blk, {BLOCK_SHIFT{1'b0}}});
               ok_in       = 1'b1;
               state_in    = ST_REPORT;
            end else if (nxt_ff < words_ff) begin
               chk_in      = 1'b1;
               chk_word_in = nxt_ff[WORD_AW-1:0];
               nxt_in      = nxt_ff + 1'b1;
            end else begin
               chk_in = 1'b0;
               if (!chk_ff) begin
                  state_in = ST_REPORT;
               end
            end
         end
         ST_F1_RD: begin
            mem_raddr = blk_ff[BLK_AW-1:BIT_AW];
            state_in  = ST_F1_WR;
         end
         ST_F1_WR: begin
            mem_we    = 1'b1;
            mem_waddr = blk_ff[BLK_AW-1:BIT_AW];
            mem_wdata = rdata_ff & ~(WORD_BITS'(1) << blk_ff[BIT_AW-1:0]);
            used_in   = (used_ff != '0) ? (used_ff - 1'b1) : '0;
            state_in  = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state; reset starts the all-ones clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         used_ff       <= CNT_W'(MAX_BLOCKS);
         sweep_ff      <= '0;
         rep_after_ff  <= 1'b0;
         wr_pend_ff    <= 1'b0;
         issue_done_ff <= 1'b0;
         chk_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         sweep_ff      <= sweep_in;
         rep_after_ff  <= rep_after_in;
         wr_pend_ff    <= wr_pend_in;
         issue_done_ff <= issue_done_in;
         chk_ff        <= chk_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      e_ff         <= e_in;
      set_ff       <= set_in;
      start_blk_ff <= start_blk_in;
      last_blk_ff  <= last_blk_in;
      n_ff         <= n_in;
      rd_word_ff   <= rd_word_in;
      wr_word_ff   <= wr_word_in;
      words_ff     <= words_in;
      nxt_ff       <= nxt_in;
      chk_word_ff  <= chk_word_in;
      blk_ff       <= blk_in;
      res_addr_ff  <= res_addr_in;
      ok_ff        <= ok_in;
   end

   // Bitmap memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= bitmap_mem[mem_raddr];
   end

   assign idle              = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_REPORT);
   assign rsp.block_address = res_addr_ff;
   assign rsp.success       = ok_ff;
   assign rsp.used_blocks   = OUT_CNT_W'(used_ff);
   assign rsp.free_blocks   = OUT_CNT_W'(free_cnt);

   `BFA_ASSERT_IMPLIES(a_used_bound, clock, reset, 1'b1, used_ff <= CNT_W'(MAX_BLOCKS))
   `BFA_ASSERT_IMPLIES(a_no_write_idle, clock, reset, state_ff == ST_IDLE || state_ff == ST_REPORT, !mem_we)
   `BFA_ASSERT_IMPLIES(a_start_idle, clock, reset, start, state_ff == ST_IDLE)
   `BFA_ASSERT_NEXT(a_alloc_count, clock, reset, state_ff == ST_SCAN && found, used_ff == $past(used_ff) + 1'b1)

endmodule

[rtl/bitmap_frame_allocator.sv]
// One operation at a time: req_tready returns when the result is loaded into rsp_tvalid's
// register, and the bitmap walk handles one word per cycle. Reset (synchronous, active high):
// a sweep sets every bitmap word to ones with req_tready low; size reg 131072 KiB.
// Top level of the bitmap frame allocator.
module bitmap_frame_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bfa_pkg::REQ_DATA_W-1:0]      req_tdata,   // address, size_bytes
   input  logic [bfa_pkg::FUNC_W-1:0]          req_tuser,   // func
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bfa_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // block_address, used, free
   output logic [bfa_pkg::RSP_USER_W-1:0]      rsp_tuser,   // success
   input  logic                                csr_write_enable,
   input  logic [bfa_pkg::MKB_W-1:0]           csr_write_data
);
   import bfa_pkg::*;

   logic [MKB_W-1:0]      mkb_ff;
   logic [CNT_W-1:0]      total;
   bfa_cmd_type           cmd;
   bfa_rsp_type           eng_rsp;
   logic                  eng_idle;
   logic                  eng_rsp_valid;
   logic                  start;
   logic                  out_free;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   // Memory size register
   always_ff @(posedge clock) begin
      if (reset) begin
         mkb_ff <= MKB_RESET;
      end else if (csr_write_enable) begin
         mkb_ff <= csr_write_data;
      end
   end

   assign total = bfa_block_total(mkb_ff);

   // Request unpacking
   assign cmd.func       = req_tuser;
   assign cmd.address    = req_tdata[ADDR_W-1:0];
   assign cmd.size_bytes = req_tdata[ADDR_W+SIZE_W-1:ADDR_W];
   assign req_tready     = eng_idle;
   assign start          = req_tvalid && eng_idle;

   assign out_free = !rsp_valid_ff || rsp_tready;

   bfa_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .total     (total),
      .out_free  (out_free),
      .idle      (eng_idle),
      .rsp_valid (eng_rsp_valid),
      .rsp       (eng_rsp)
   );

   // Result register: a transfer empties it, the engine refills it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_rsp_valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_rsp_valid && out_free) begin
         rsp_data_ff <= {eng_rsp.free_blocks, eng_rsp.used_blocks, eng_rsp.block_address};
         rsp_user_ff <= eng_rsp.success;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[sim/bitmap_frame_allocator_tb.sv]
// Self-checking testbench for the bitmap frame allocator: directed and random traffic.
module bitmap_frame_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bfa_pkg::*;

   localparam int CLK_PERIOD    = 4;
   localparam int RESET_CYCLES  = 3;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 1100;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 20000;

   // Operation codes the block does nothing with
   localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;   // address, size_bytes
   logic [FUNC_W-1:0]       req_tuser;   // func
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;   // block_address, used_blocks, free_blocks
   logic [RSP_USER_W-1:0]   rsp_tuser;   // success
   logic                    csr_write_enable;
   logic [MKB_W-1:0]        csr_write_data;

   // Predictor state
   logic [WORD_BITS-1:0] frame_words [WORD_COUNT];
   int unsigned          used_frames;
   logic [MKB_W-1:0]     model_kib;

   bfa_rsp_type expected_rsp_q [$];

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int hold_requests     = 0;
   int error_count       = 0;
   int items_sent        = 0;
   int results_checked   = 0;
   int alloc_hits        = 0;
   int sizes_written     = 0;

   bitmap_frame_allocator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Usable blocks for a memory size, capped at the bitmap size
   function automatic int unsigned block_count(input logic [MKB_W-1:0] kib);
      longint unsigned n;
      n = (longint'(kib) * 1024) / BLOCK_BYTES;
      if (n > MAX_BLOCKS) begin
         n = MAX_BLOCKS;
      end
      return int'(n);
   endfunction

   // Set or clear a run of blocks, clipped to the block count
   function automatic void mark_region(input logic [ADDR_W-1:0] base,
                                       input logic [SIZE_W-1:0] len,
                                       input bit set_used, input int unsigned total);
      longint unsigned first_blk;
      longint unsigned stop_blk;
      first_blk = longint'(base) >> BLOCK_SHIFT;
      stop_blk  = first_blk + (longint'(len) >> BLOCK_SHIFT);
      if (stop_blk > total) begin
         stop_blk = total;
      end
      for (longint unsigned blk = first_blk; blk < stop_blk; blk++) begin
         frame_words[blk / WORD_BITS][blk % WORD_BITS] = set_used;
         if (set_used) begin
            if (used_frames < total) used_frames++;
         end else if (used_frames > 0) begin
            used_frames--;
         end
      end
   endfunction

   // Apply one operation to the bitmap and give the response it produces
   function automatic bfa_rsp_type predict_response(input logic [FUNC_W-1:0] func,
                                                    input logic [ADDR_W-1:0] address,
                                                    input logic [SIZE_W-1:0] size_bytes);
      bfa_rsp_type    rsp;
      int unsigned    total;
      int unsigned    blk;
      bit             found;
      total = block_count(model_kib);
      rsp   = '0;
      found = 1'b0;
      case (func)
         FUNC_INIT: begin
            foreach (frame_words[w]) frame_words[w] = '1;
            used_frames = total;
         end
         FUNC_FREE_REGION: begin
            mark_region(address, size_bytes, 1'b0, total);
            // block 0 stays reserved whenever there are any blocks
            if (total > 0) frame_words[0][0] = 1'b1;
         end
         FUNC_RESERVE_REGION: begin
            mark_region(address, size_bytes, 1'b1, total);
         end
         FUNC_ALLOC: begin
            // only whole words below the block count are searched
            if (used_frames < total) begin
               for (int w = 0; w < int'(total / WORD_BITS) && !found; w++) begin
                  if (frame_words[w] != '1) begin
                     for (int b = 0; b < WORD_BITS && !found; b++) begin
                        if (!frame_words[w][b]) begin
                           frame_words[w][b] = 1'b1;
                           used_frames++;
                           rsp.block_address = ADDR_W'((w * WORD_BITS + b) << BLOCK_SHIFT);
                           rsp.success       = 1'b1;
                           found             = 1'b1;
                           alloc_hits++;
                        end
                     end
                  end
               end
            end
         end
         FUNC_FREE_ONE: begin
            blk = address >> BLOCK_SHIFT;
            if (blk < total) begin
               frame_words[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
               if (used_frames > 0) used_frames--;
            end
         end
         default: begin
         end
      endcase
      rsp.used_blocks = OUT_CNT_W'(used_frames);
      rsp.free_blocks = (total > used_frames) ? OUT_CNT_W'(total - used_frames) : '0;
      return rsp;
   endfunction

   // Offer one command and record its expected response once transferred
   task automatic send_command(input logic [FUNC_W-1:0] func,
                               input logic [ADDR_W-1:0] address,
                               input logic [SIZE_W-1:0] size_bytes);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {size_bytes, address};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      expected_rsp_q.push_back(predict_response(func, address, size_bytes));
      items_sent++;
   endtask

   // Stop offering and wait until every response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (expected_rsp_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_memory_size(input logic [MKB_W-1:0] kib);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= kib;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_kib = kib;
      sizes_written++;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_idle_pct <= receiver_pct;
   endtask

   // Every operation, many at the field extremes, on the reset memory size
   task automatic test_directed_operations();
      send_command(FUNC_ALLOC, '0, '0);                          // everything used
      send_command(FUNC_FREE_REGION, '0, 32'h0001_0000);
      send_command(FUNC_ALLOC, '1, '1);
      send_command(FUNC_FREE_ONE, '1, '0);                       // beyond block count
      send_command(FUNC_FREE_ONE, 32'h0000_5ABC, '1);
      send_command(FUNC_RESERVE_REGION, 32'h0000_2000, 32'h0000_3FFF);
      send_command(FUNC_FREE_REGION, '1, '1);                    // starts out of range
      send_command(FUNC_RESERVE_REGION, '0, '1);                 // count saturates high
      for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++) begin
         send_command(FUNC_W'(f), $urandom(), $urandom());
      end
      send_command(FUNC_INIT, '1, '1);
      send_command(FUNC_FREE_REGION, '0, '1);                    // count saturates low
      send_command(FUNC_FREE_ONE, '0, '0);
      send_command(FUNC_ALLOC, '0, '0);
   endtask

   // Shrinking and growing the memory size under a live bitmap
   task automatic test_memory_size_changes();
      write_memory_size(18'd160);                                // 40 blocks
      send_command(FUNC_FREE_ONE, 32'd35 << BLOCK_SHIFT, '0);    // inside the new block count
      send_command(FUNC_INIT, '0, '0);
      send_command(FUNC_FREE_ONE, 32'd35 << BLOCK_SHIFT, '0);
      send_command(FUNC_ALLOC, '0, '0);                          // free block in partial word
      send_command(FUNC_FREE_ONE, 32'd7 << BLOCK_SHIFT, '0);
      send_command(FUNC_ALLOC, '0, '0);
      write_memory_size('0);                                     // no blocks at all
      send_command(FUNC_FREE_REGION, '0, '1);
      send_command(FUNC_ALLOC, '0, '0);
      send_command(FUNC_RESERVE_REGION, '0, 32'h0001_0000);
      write_memory_size('1);                                     // capped at the bitmap size
      send_command(FUNC_FREE_ONE, 32'h07FF_F000, '0);
      send_command(FUNC_ALLOC, '0, '0);
      send_command(FUNC_FREE_ONE, 32'h7FFF_FFFF, '0);
   endtask

   // Random commands, mostly inside the block range, with some raw noise
   task automatic test_random_traffic(input logic [MKB_W-1:0] kib, input int count);
      int unsigned        total;
      int unsigned        pick;
      logic [FUNC_W-1:0]  func;
      logic [ADDR_W-1:0]  address;
      logic [SIZE_W-1:0]  size_bytes;
      write_memory_size(kib);
      total = block_count(kib);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 2)       func = FUNC_INIT;
         else if (pick < 5)  func = FUNC_W'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
         else if (pick < 25) func = FUNC_FREE_REGION;
         else if (pick < 37) func = FUNC_RESERVE_REGION;
         else if (pick < 70) func = FUNC_ALLOC;
         else                func = FUNC_FREE_ONE;
         if ($urandom_range(9) == 0) begin
            address = $urandom();
         end else begin
            address = ($urandom_range(total + 8) << BLOCK_SHIFT) | $urandom_range(BLOCK_BYTES - 1);
         end
         pick = $urandom_range(19);
         if (pick == 0) begin
            size_bytes = $urandom();
         end else if (pick == 1) begin
            size_bytes = $urandom_range(total) << BLOCK_SHIFT;
         end else begin
            size_bytes = ($urandom_range(48) << BLOCK_SHIFT) | $urandom_range(BLOCK_BYTES - 1);
         end
         send_command(func, address, size_bytes);
      end
   endtask

   // Long receiver hold-off while commands keep coming, then a full drain
   task automatic test_output_backpressure();
      int unsigned total;
      drain_responses();
      total = block_count(model_kib);
      hold_requests <= hold_requests + 1;
      for (int n = 0; n < 24; n++) begin
         if (n % 2 == 0) begin
            send_command(FUNC_FREE_ONE, $urandom_range(total) << BLOCK_SHIFT, $urandom());
         end else begin
            send_command(FUNC_ALLOC, $urandom(), $urandom());
         end
      end
      drain_responses();
   endtask

   // Receiver: random ready, with long hold-offs on request
   initial begin : receiver
      int served;
      int hold_left;
      served     = 0;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (served != hold_requests) begin
            served    = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Response check against the oldest expectation, sampled mid-cycle
   always @(negedge clock) begin : response_check
      bfa_rsp_type want;
      bfa_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.block_address = rsp_tdata[31:0];
         got.used_blocks   = rsp_tdata[47:32];
         got.free_blocks   = rsp_tdata[63:48];
         got.success       = rsp_tuser[0];
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected response transfer: %h / %b", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            results_checked++;
            if (got.block_address !== want.block_address) begin
               $error("block_address: expected %h, got %h", want.block_address, got.block_address);
               error_count++;
            end
            if (got.success !== want.success) begin
               $error("success: expected %b, got %b", want.success, got.success);
               error_count++;
            end
            if (got.used_blocks !== want.used_blocks) begin
               $error("used_blocks: expected %0d, got %0d", want.used_blocks, got.used_blocks);
               error_count++;
            end
            if (got.free_blocks !== want.free_blocks) begin
               $error("free_blocks: expected %0d, got %0d", want.free_blocks, got.free_blocks);
               error_count++;
            end
         end
      end
   end

   // Watchdog: ends the run after too long without any transfer
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(negedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // Main sequence
   initial begin : main_sequence
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      model_kib        = MKB_RESET;
      foreach (frame_words[w]) frame_words[w] = '1;
      used_frames = block_count(MKB_RESET);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      set_idling(31, 72);
      test_directed_operations();
      test_memory_size_changes();
      test_random_traffic(18'd4096, 300);
      test_random_traffic(18'd160, 150);
      test_output_backpressure();

      set_idling(72, 31);
      test_random_traffic(18'd1000, 300);
      test_random_traffic('0, 50);

      set_idling(0, 0);
      test_random_traffic(18'd8191, 300);
      test_random_traffic('1, 150);
      test_random_traffic(MKB_RESET, 150);
      test_random_traffic(18'd4096, 300);

      drain_responses();
      repeat (END_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp_q.size());
         error_count++;
      end
      $display("Covered %0d commands and %0d checked responses over %0d memory sizes,",
               items_sent, results_checked, sizes_written);
      $display("with %0d successful allocations and a long output hold-off.", alloc_hits);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
